/* rtl/plsr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the logic/shift/rotate unit.
// No dependencies; imported by every module of the block.
package plsr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IMM_W  = 16;
    localparam int unsigned SH_W   = 5;
    localparam int unsigned OP_W   = 5;
    localparam int unsigned CR_W   = 4;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    // Instruction codes on the operation field; 21..31 are unused
    typedef enum logic [OP_W-1:0] {
        OP_AND    = 5'd0,
        OP_ANDC   = 5'd1,
        OP_OR     = 5'd2,
        OP_ORC    = 5'd3,
        OP_XOR    = 5'd4,
        OP_NAND   = 5'd5,
        OP_NOR    = 5'd6,
        OP_EQV    = 5'd7,
        OP_ANDI   = 5'd8,
        OP_ANDIS  = 5'd9,
        OP_ORI    = 5'd10,
        OP_ORIS   = 5'd11,
        OP_XORI   = 5'd12,
        OP_XORIS  = 5'd13,
        OP_SLW    = 5'd14,
        OP_SRW    = 5'd15,
        OP_SRAW   = 5'd16,
        OP_SRAWI  = 5'd17,
        OP_RLWIMI = 5'd18,
        OP_RLWINM = 5'd19,
        OP_RLWNM  = 5'd20
    } t_op;

    // Shift/rotate unit result toward the result select
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              carry;
        logic              carry_write;
    } t_shift_out;

endpackage

/* rtl/powerpc_logic_shift_rotate_unit.sv */
`timescale 1ns / 1ps
// PowerPC 32-bit logical, shift and rotate unit: input register, logic and
// shift/rotate units, CR0/CA generation, result register.
// Depends on plsr_pkg, plsr_logic and plsr_shift.
//
// Takes one instruction per clock while o_stall is low and returns one result
// for each, passing through the input register and then the result register.
// The whole operation is one pass of combinational logic between those two
// registers; stall from the output side reaches the input side only when
// both registers are full. CR0 is written for record forms and always for
// andi./andis.; CA is written for sraw and srawi. Unused operation codes pass
// the old target value through with no CR0 or CA update.
module powerpc_logic_shift_rotate_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Instruction channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [plsr_pkg::OP_W-1:0]   i_operation,
    input  logic [plsr_pkg::DATA_W-1:0] i_source_value,
    input  logic [plsr_pkg::DATA_W-1:0] i_operand_b_value,
    input  logic [plsr_pkg::DATA_W-1:0] i_old_target_value,
    input  logic [plsr_pkg::IMM_W-1:0]  i_immediate,
    input  logic [plsr_pkg::SH_W-1:0]   i_shift_field,
    input  logic [plsr_pkg::SH_W-1:0]   i_mask_begin,
    input  logic [plsr_pkg::SH_W-1:0]   i_mask_end,
    input  logic                        i_record_bit,
    input  logic                        i_summary_overflow_in,
    // Result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [plsr_pkg::DATA_W-1:0] o_result_value,
    output logic [plsr_pkg::CR_W-1:0]   o_cr0_bits,
    output logic                        o_cr0_write,
    output logic                        o_carry_out,
    output logic                        o_carry_write
);
    import plsr_pkg::*;

    // Input register
    logic                r_in_valid;
    logic [OP_W-1:0]     r_op;
    logic [DATA_W-1:0]   r_s;
    logic [DATA_W-1:0]   r_b;
    logic [DATA_W-1:0]   r_old;
    logic [IMM_W-1:0]    r_imm;
    logic [SH_W-1:0]     r_sh;
    logic [SH_W-1:0]     r_mb;
    logic [SH_W-1:0]     r_me;
    logic                r_rc;
    logic                r_so;

    // Result register
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_result;
    logic [CR_W-1:0]     r_cr0;
    logic                r_cr0_wr;
    logic                r_ca;
    logic                r_ca_wr;

    logic                out_free;
    logic                in_take;
    logic [DATA_W-1:0]   logic_value;
    t_shift_out          shift_res;
    logic [DATA_W-1:0]   n_result;
    logic                n_cr0_wr;
    logic [CR_W-1:0]     n_cr0;
    logic                n_ca;
    logic                n_ca_wr;

    // Flow control: result register frees when empty or being taken
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= i_operation;
            r_s   <= i_source_value;
            r_b   <= i_operand_b_value;
            r_old <= i_old_target_value;
            r_imm <= i_immediate;
            r_sh  <= i_shift_field;
            r_mb  <= i_mask_begin;
            r_me  <= i_mask_end;
            r_rc  <= i_record_bit;
            r_so  <= i_summary_overflow_in;
        end
    end

    // Execution units
    plsr_logic u_logic (
        .i_op    (r_op),
        .i_s     (r_s),
        .i_b     (r_b),
        .i_imm   (r_imm),
        .o_value (logic_value)
    );

    plsr_shift u_shift (
        .i_op  (r_op),
        .i_s   (r_s),
        .i_b   (r_b),
        .i_old (r_old),
        .i_sh  (r_sh),
        .i_mb  (r_mb),
        .i_me  (r_me),
        .o_res (shift_res)
    );

    // Result select, CR0 enable and CA select
    always_comb begin
        n_result = r_old;
        n_cr0_wr = 1'b0;
        n_ca     = 1'b0;
        n_ca_wr  = 1'b0;
        if (r_op inside {[OP_AND:OP_EQV]}) begin
            n_result = logic_value;
            n_cr0_wr = r_rc;
        end else if (r_op inside {OP_ANDI, OP_ANDIS}) begin
            n_result = logic_value;
            n_cr0_wr = 1'b1;
        end else if (r_op inside {[OP_ORI:OP_XORIS]}) begin
            n_result = logic_value;
        end else if (r_op inside {[OP_SLW:OP_RLWNM]}) begin
            n_result = shift_res.value;
            n_cr0_wr = r_rc;
            n_ca     = shift_res.carry;
            n_ca_wr  = shift_res.carry_write;
        end
    end

    // CR0: LT/GT/EQ of the signed result plus SO; zero when not written
    always_comb begin
        n_cr0 = '0;
        if (n_cr0_wr) begin
            n_cr0[3] = n_result[DATA_W-1];
            n_cr0[2] = !n_result[DATA_W-1] && (|n_result);
            n_cr0[1] = !(|n_result);
            n_cr0[0] = r_so;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_result <= n_result;
            r_cr0    <= n_cr0;
            r_cr0_wr <= n_cr0_wr;
            r_ca     <= n_ca && n_ca_wr;
            r_ca_wr  <= n_ca_wr;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_result;
    assign o_cr0_bits     = r_cr0;
    assign o_cr0_write    = r_cr0_wr;
    assign o_carry_out    = r_ca;
    assign o_carry_write  = r_ca_wr;

    // Input side stalls only when a result is held and the next one waits
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && o_valid && i_stall))
        else $error("input stalled while pipeline has room");

    // Exactly one of LT/GT/EQ when CR0 is written
    a_cr0_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cr0_write) |-> $onehot(o_cr0_bits[3:1]))
        else $error("CR0 compare bits not one-hot");

    // CR0 field reads zero when not written
    a_cr0_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_cr0_write) |-> (o_cr0_bits == '0))
        else $error("CR0 bits set without CR0 write");

    // Carry reads zero when not written
    a_ca_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_carry_write) |-> !o_carry_out)
        else $error("carry set without carry write");

endmodule

/* rtl/plsr_logic.sv */
`timescale 1ns / 1ps
// Bitwise logic ops, register and unsigned-immediate forms.
// Depends on plsr_pkg.
module plsr_logic (
    input  logic [plsr_pkg::OP_W-1:0]   i_op,
    input  logic [plsr_pkg::DATA_W-1:0] i_s,
    input  logic [plsr_pkg::DATA_W-1:0] i_b,
    input  logic [plsr_pkg::IMM_W-1:0]  i_imm,
    output logic [plsr_pkg::DATA_W-1:0] o_value
);
    import plsr_pkg::*;

    logic [DATA_W-1:0] imm_lo;
    logic [DATA_W-1:0] imm_hi;

    // Zero-extended immediate and its shifted form
    assign imm_lo = {{(DATA_W-IMM_W){1'b0}}, i_imm};
    assign imm_hi = {i_imm, {(DATA_W-IMM_W){1'b0}}};

    always_comb begin
        case (i_op)
            OP_AND:   o_value = i_s & i_b;
            OP_ANDC:  o_value = i_s & ~i_b;
            OP_OR:    o_value = i_s | i_b;
            OP_ORC:   o_value = i_s | ~i_b;
            OP_XOR:   o_value = i_s ^ i_b;
            OP_NAND:  o_value = ~(i_s & i_b);
            OP_NOR:   o_value = ~(i_s | i_b);
            OP_EQV:   o_value = ~(i_s ^ i_b);
            OP_ANDI:  o_value = i_s & imm_lo;
            OP_ANDIS: o_value = i_s & imm_hi;
            OP_ORI:   o_value = i_s | imm_lo;
            OP_ORIS:  o_value = i_s | imm_hi;
            OP_XORI:  o_value = i_s ^ imm_lo;
            OP_XORIS: o_value = i_s ^ imm_hi;
            default:  o_value = '0;
        endcase
    end

endmodule

/* rtl/plsr_shift.sv */
`timescale 1ns / 1ps
// Shifts (slw/srw/sraw/srawi) and rotate-and-mask ops (rlwimi/rlwinm/rlwnm).
// Depends on plsr_pkg.
module plsr_shift (
    input  logic [plsr_pkg::OP_W-1:0]   i_op,
    input  logic [plsr_pkg::DATA_W-1:0] i_s,
    input  logic [plsr_pkg::DATA_W-1:0] i_b,
    input  logic [plsr_pkg::DATA_W-1:0] i_old,
    input  logic [plsr_pkg::SH_W-1:0]   i_sh,
    input  logic [plsr_pkg::SH_W-1:0]   i_mb,
    input  logic [plsr_pkg::SH_W-1:0]   i_me,
    output plsr_pkg::t_shift_out        o_res
);
    import plsr_pkg::*;

    logic [SH_W-1:0]     rot_amt;
    logic [2*DATA_W-1:0] rot_wide;
    logic [DATA_W-1:0]   rotated;
    logic [DATA_W-1:0]   mask_lo;
    logic [DATA_W-1:0]   mask_hi;
    logic [DATA_W-1:0]   mask;
    logic                big_amt;
    logic [SH_W-1:0]     sra_n;
    logic [SH_W-1:0]     sra_amt;
    logic [DATA_W-1:0]   lost_mask;
    logic [DATA_W-1:0]   sra_val;
    logic                sra_ca;

    // Rotate left: upper half of the doubled word shifted left
    always_comb begin
        rot_amt  = (i_op == OP_RLWNM) ? i_b[SH_W-1:0] : i_sh;
        rot_wide = {i_s, i_s} << rot_amt;
        rotated  = rot_wide[2*DATA_W-1:DATA_W];
    end

    // MB/ME mask, big-endian bit numbering; wraps when MB > ME
    always_comb begin
        mask_lo = ALL_ONES >> i_mb;
        mask_hi = ALL_ONES << (SH_W'(DATA_W - 1) - i_me);
        mask    = (i_mb <= i_me) ? (mask_lo & mask_hi) : (mask_lo | mask_hi);
    end

    // Arithmetic right shift; amounts of 32..63 give the sign fill
    always_comb begin
        big_amt   = (i_op == OP_SRAW) && i_b[SH_W];
        sra_n     = (i_op == OP_SRAW) ? i_b[SH_W-1:0] : i_sh;
        sra_amt   = big_amt ? SH_W'(DATA_W - 1) : sra_n;
        lost_mask = big_amt ? ALL_ONES : ~(ALL_ONES << sra_n);
        sra_val   = DATA_W'($signed(i_s) >>> sra_amt);
        sra_ca    = i_s[DATA_W-1] && (|(i_s & lost_mask));
    end

    // Per-op result
    always_comb begin
        o_res = '0;
        case (i_op)
            OP_SLW:    o_res.value = i_b[SH_W] ? '0 : (i_s << i_b[SH_W-1:0]);
            OP_SRW:    o_res.value = i_b[SH_W] ? '0 : (i_s >> i_b[SH_W-1:0]);
            OP_SRAW, OP_SRAWI: begin
                o_res.value       = sra_val;
                o_res.carry       = sra_ca;
                o_res.carry_write = 1'b1;
            end
            OP_RLWIMI: o_res.value = (i_old & ~mask) | (rotated & mask);
            OP_RLWINM: o_res.value = rotated & mask;
            OP_RLWNM:  o_res.value = rotated & mask;
            default:   o_res.value = i_old;
        endcase
    end

endmodule
